FILE: src/lfbfs_pkg.sv
// Package for the label-filtered path engine: sizes, opcodes, status codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package lfbfs_pkg;
    localparam int VERTICES = 64;
    localparam int EDGES_PER_VERTEX = 16;
    localparam int LABELS = 16;
    localparam int COUNT_BITS = 8;
    localparam int VW = 6;
    localparam int EW = 4;
    localparam int LW = 4;
    localparam int ECW = 5;
    localparam int VTW = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_VERTEX = 3'd0, OP_EDGE = 3'd1, OP_ADD = 3'd2, OP_REMOVE = 3'd3,
        OP_PATH = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_BAD = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LBL_RD, S_LBL_CHK, S_VCLR, S_CLR, S_POP, S_POP_W, S_EDGE_RD,
        S_EDGE_W, S_NB_LBL, S_NB_CHK, S_DONE_CHK, S_WALK_RD, S_WALK_W,
        S_EMIT_RD, S_EMIT, S_RESULT
    } state_t;
endpackage

FILE: src/lfbfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lfbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/label_filtered_bfs_path_engine_top.sv
// Top level of the label-filtered path engine: sequencer and graph stores.
// Depends on lfbfs_pkg and lfbfs_ram.
`timescale 1ns / 1ps
// Use: drive opcode, vertex_a, vertex_b and label_id with start high while
// busy is low; the item is taken at that edge and busy rises next cycle.
// Results appear on status, path_vertex, path_position and last, each for
// one cycle marked by strobe; last marks the final result of an item. The
// receiver cannot stall, so results are never held. A single result is on
// the ports in the first cycle that busy is low again.
// Sequencing: edge append and label operations read, check and finish.
// A vertex create clears the new vertex's label row, one entry per cycle,
// and its edge count; on a full store it finishes without clearing.
// A path query clears its visited marks (flip-flops), then runs the
// search on the shared memory read ports, dequeuing vertices and reading
// their edges; then it traces the path back through the parent memory
// and emits one result per path vertex, each after a read of the path
// buffer.
// Unused opcodes give no result and return to idle.
// Reset: asynchronous, active low; empties the graph (vertex count to
// zero). Label rows and edge counts are cleared when a vertex is created,
// so no clearing pass follows reset. Edge targets need no clear.
module label_filtered_bfs_path_engine_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    input  logic [3:0] label_id,
    output logic       strobe,
    output logic [2:0] status,
    output logic [5:0] path_vertex,
    output logic [5:0] path_position,
    output logic       last
);
    localparam int VW = lfbfs_pkg::VW;
    localparam int LAW = VW + lfbfs_pkg::LW;
    localparam int EAW = VW + lfbfs_pkg::EW;
    localparam int CB = lfbfs_pkg::COUNT_BITS;
    localparam int ECW = lfbfs_pkg::ECW;

    lfbfs_pkg::state_t state_reg, state_next;

    logic [2:0]    op_reg;
    logic [VW-1:0] a_reg, b_reg;
    logic [3:0]    l_reg;
    logic [lfbfs_pkg::VTW-1:0] vtot_reg, vtot_next;
    logic [lfbfs_pkg::VERTICES-1:0] vis_reg;
    logic [lfbfs_pkg::VERTICES-1:0] pvalid_reg;
    logic [VW:0]   head_reg, tail_reg, n_reg, k_reg;
    logic [VW-1:0] cur_reg, walk_reg, nx_reg;
    logic [ECW-1:0] e_reg;
    logic [lfbfs_pkg::LW:0]    clr_reg;

    // status of a single-result item, latched during the sequence
    logic [2:0]    rstat_reg;
    logic [VW-1:0] rv_reg;

    // label counts memory
    logic            lab_we;
    logic [LAW-1:0]  lab_waddr, lab_raddr;
    logic [CB-1:0]   lab_wdata, lab_rdata;
    // edge target memory
    logic            edg_we;
    logic [EAW-1:0]  edg_raddr;
    logic [VW-1:0]   edg_rdata;
    // edge count memory
    logic            cnt_we;
    logic [VW-1:0]   cnt_waddr, cnt_raddr;
    logic [ECW-1:0]  cnt_wdata, cnt_rdata;
    // search queue memory
    logic            q_we;
    logic [VW-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;
    // parent memory
    logic            par_we;
    logic [VW-1:0]   par_waddr, par_raddr, par_wdata, par_rdata;
    // path buffer memory
    logic            pb_we;
    logic [VW-1:0]   pb_waddr, pb_raddr, pb_wdata, pb_rdata;

    lfbfs_ram #(.WIDTH(CB), .DEPTH(lfbfs_pkg::VERTICES * lfbfs_pkg::LABELS)) u_lab (
        .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .raddr(lab_raddr), .rdata(lab_rdata)
    );
    lfbfs_ram #(.WIDTH(VW), .DEPTH(lfbfs_pkg::VERTICES * lfbfs_pkg::EDGES_PER_VERTEX))
        u_edg (
        .clk(clk), .we(edg_we),
        .waddr({a_reg, cnt_rdata[lfbfs_pkg::EW-1:0]}), .wdata(b_reg),
        .raddr(edg_raddr), .rdata(edg_rdata)
    );
    lfbfs_ram #(.WIDTH(ECW), .DEPTH(lfbfs_pkg::VERTICES)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    lfbfs_ram #(.WIDTH(VW), .DEPTH(lfbfs_pkg::VERTICES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    lfbfs_ram #(.WIDTH(VW), .DEPTH(lfbfs_pkg::VERTICES)) u_par (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    lfbfs_ram #(.WIDTH(VW), .DEPTH(lfbfs_pkg::VERTICES)) u_pbuf (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_rdata)
    );

    logic a_bad, b_bad, lbl_has, edge_room, nb_take, walk_more;
    assign a_bad = {1'b0, a_reg} >= vtot_reg;
    assign b_bad = {1'b0, b_reg} >= vtot_reg;
    assign lbl_has = lab_rdata != '0;
    // edge count of vertex_a, read in the cycle before the check
    assign edge_room = cnt_rdata < ECW'(lfbfs_pkg::EDGES_PER_VERTEX);
    // enqueue an unvisited labelled neighbour while the queue has room
    assign nb_take = !vis_reg[nx_reg] && lbl_has && tail_reg < 7'(lfbfs_pkg::VERTICES);
    assign walk_more = walk_reg != a_reg && n_reg < 7'(lfbfs_pkg::VERTICES);

    // result staging
    logic          res_en;
    logic [2:0]    res_st;
    logic [VW-1:0] res_v, res_p;
    logic          res_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfbfs_pkg::S_IDLE:
                if (start) state_next = lfbfs_pkg::S_LBL_RD;
            lfbfs_pkg::S_LBL_RD:
                unique case (op_reg)
                    lfbfs_pkg::OP_VERTEX:
                        state_next = (vtot_reg >= lfbfs_pkg::VTW'(lfbfs_pkg::VERTICES))
                            ? lfbfs_pkg::S_RESULT : lfbfs_pkg::S_VCLR;
                    lfbfs_pkg::OP_EDGE, lfbfs_pkg::OP_ADD, lfbfs_pkg::OP_REMOVE,
                    lfbfs_pkg::OP_PATH:
                        state_next = lfbfs_pkg::S_LBL_CHK;
                    default: state_next = lfbfs_pkg::S_IDLE;
                endcase
            lfbfs_pkg::S_LBL_CHK:
                if (op_reg == lfbfs_pkg::OP_PATH && !a_bad && !b_bad && lbl_has)
                    state_next = lfbfs_pkg::S_CLR;
                else
                    state_next = lfbfs_pkg::S_RESULT;
            lfbfs_pkg::S_VCLR:
                if (clr_reg == 5'(lfbfs_pkg::LABELS - 1)) state_next = lfbfs_pkg::S_RESULT;
            lfbfs_pkg::S_CLR: state_next = lfbfs_pkg::S_POP;
            lfbfs_pkg::S_POP:
                state_next = (head_reg < tail_reg) ? lfbfs_pkg::S_POP_W
                                                   : lfbfs_pkg::S_DONE_CHK;
            lfbfs_pkg::S_POP_W: state_next = lfbfs_pkg::S_EDGE_RD;
            lfbfs_pkg::S_EDGE_RD:
                state_next = (e_reg < cnt_rdata) ? lfbfs_pkg::S_EDGE_W
                                                 : lfbfs_pkg::S_POP;
            lfbfs_pkg::S_EDGE_W: state_next = lfbfs_pkg::S_NB_LBL;
            lfbfs_pkg::S_NB_LBL: state_next = lfbfs_pkg::S_NB_CHK;
            lfbfs_pkg::S_NB_CHK:
                state_next = (nx_reg == b_reg) ? lfbfs_pkg::S_DONE_CHK
                                               : lfbfs_pkg::S_EDGE_RD;
            lfbfs_pkg::S_DONE_CHK:
                state_next = pvalid_reg[b_reg] ? lfbfs_pkg::S_WALK_RD
                                               : lfbfs_pkg::S_RESULT;
            lfbfs_pkg::S_WALK_RD:
                state_next = walk_more ? lfbfs_pkg::S_WALK_W : lfbfs_pkg::S_EMIT_RD;
            lfbfs_pkg::S_WALK_W: state_next = lfbfs_pkg::S_WALK_RD;
            lfbfs_pkg::S_EMIT_RD: state_next = lfbfs_pkg::S_EMIT;
            lfbfs_pkg::S_EMIT:
                state_next = (k_reg + 7'd1 == n_reg) ? lfbfs_pkg::S_IDLE
                                                     : lfbfs_pkg::S_EMIT_RD;
            lfbfs_pkg::S_RESULT: state_next = lfbfs_pkg::S_IDLE;
            default: state_next = lfbfs_pkg::S_IDLE;
        endcase
    end

    // outputs: memory controls and results
    always_comb
    begin
        lab_we = 1'b0;
        lab_waddr = {a_reg, l_reg};
        lab_wdata = lab_rdata;
        lab_raddr = {a_reg, l_reg};
        edg_we = 1'b0;
        edg_raddr = {cur_reg, e_reg[lfbfs_pkg::EW-1:0]};
        cnt_we = 1'b0;
        cnt_waddr = a_reg;
        cnt_wdata = cnt_rdata + 5'd1;
        cnt_raddr = a_reg;
        q_we = 1'b0;
        q_waddr = tail_reg[VW-1:0];
        q_wdata = nx_reg;
        q_raddr = head_reg[VW-1:0];
        par_we = 1'b0;
        par_waddr = nx_reg;
        par_wdata = cur_reg;
        par_raddr = walk_reg;
        pb_we = 1'b0;
        pb_waddr = n_reg[VW-1:0];
        pb_wdata = par_rdata;
        pb_raddr = 6'(n_reg - 7'd1 - k_reg);
        vtot_next = vtot_reg;
        res_en = 1'b0;
        res_st = lfbfs_pkg::ST_OK;
        res_v = '0;
        res_p = '0;
        res_last = 1'b1;
        unique case (state_reg)
            lfbfs_pkg::S_LBL_CHK:
                if (op_reg == lfbfs_pkg::OP_EDGE)
                begin
                    if (!a_bad && !b_bad && edge_room)
                    begin
                        edg_we = 1'b1;
                        cnt_we = 1'b1;
                    end
                end
                else if (op_reg == lfbfs_pkg::OP_ADD && !a_bad
                         && lab_rdata != lfbfs_pkg::COUNT_MAX)
                begin
                    lab_we = 1'b1;
                    lab_wdata = lab_rdata + CB'(1);
                end
                else if (op_reg == lfbfs_pkg::OP_REMOVE && !a_bad && lbl_has)
                begin
                    lab_we = 1'b1;
                    lab_wdata = lab_rdata - CB'(1);
                end
            lfbfs_pkg::S_VCLR:
            begin
                lab_we = 1'b1;
                lab_waddr = {vtot_reg[VW-1:0], clr_reg[lfbfs_pkg::LW-1:0]};
                lab_wdata = '0;
                if (clr_reg == 5'd0)
                begin
                    cnt_we = 1'b1;
                    cnt_waddr = vtot_reg[VW-1:0];
                    cnt_wdata = '0;
                end
                if (clr_reg == 5'(lfbfs_pkg::LABELS - 1)) vtot_next = vtot_reg + 7'd1;
            end
            lfbfs_pkg::S_CLR:
            begin
                // seed the search with the start vertex
                par_we = 1'b1;
                par_waddr = a_reg;
                par_wdata = a_reg;
                q_we = 1'b1;
                q_waddr = '0;
                q_wdata = a_reg;
            end
            // fetch the edge count of the vertex just dequeued
            lfbfs_pkg::S_POP_W: cnt_raddr = q_rdata;
            lfbfs_pkg::S_EDGE_RD, lfbfs_pkg::S_EDGE_W: cnt_raddr = cur_reg;
            lfbfs_pkg::S_NB_LBL:
            begin
                cnt_raddr = cur_reg;
                lab_raddr = {nx_reg, l_reg};
            end
            lfbfs_pkg::S_NB_CHK:
            begin
                cnt_raddr = cur_reg;
                if (nb_take)
                begin
                    par_we = 1'b1;
                    q_we = 1'b1;
                end
            end
            lfbfs_pkg::S_DONE_CHK:
                if (pvalid_reg[b_reg])
                begin
                    pb_we = 1'b1;
                    pb_waddr = '0;
                    pb_wdata = b_reg;
                end
            lfbfs_pkg::S_WALK_W: pb_we = 1'b1;
            lfbfs_pkg::S_EMIT:
            begin
                res_en = 1'b1;
                res_v = pb_rdata;
                res_p = k_reg[VW-1:0];
                res_last = (k_reg + 7'd1 == n_reg);
            end
            lfbfs_pkg::S_RESULT:
            begin
                res_en = 1'b1;
                res_st = rstat_reg;
                res_v = rv_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfbfs_pkg::S_IDLE;
            vtot_reg <= '0;
            strobe <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vtot_reg <= vtot_next;
            strobe <= res_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_en)
        begin
            status <= res_st;
            path_vertex <= res_v;
            path_position <= res_p;
            last <= res_last;
        end
        unique case (state_reg)
            lfbfs_pkg::S_IDLE:
                if (start)
                begin
                    op_reg <= opcode;
                    a_reg <= vertex_a;
                    b_reg <= vertex_b;
                    l_reg <= label_id;
                    clr_reg <= '0;
                    rstat_reg <= lfbfs_pkg::ST_OK;
                    rv_reg <= '0;
                end
            lfbfs_pkg::S_LBL_RD:
                if (op_reg == lfbfs_pkg::OP_VERTEX)
                begin
                    if (vtot_reg >= lfbfs_pkg::VTW'(lfbfs_pkg::VERTICES))
                        rstat_reg <= lfbfs_pkg::ST_FULL;
                    else
                        rv_reg <= vtot_reg[VW-1:0];
                end
            lfbfs_pkg::S_LBL_CHK:
                unique case (op_reg)
                    lfbfs_pkg::OP_EDGE:
                        if (a_bad || b_bad) rstat_reg <= lfbfs_pkg::ST_BAD;
                        else if (!edge_room) rstat_reg <= lfbfs_pkg::ST_FULL;
                    lfbfs_pkg::OP_ADD:
                        if (a_bad) rstat_reg <= lfbfs_pkg::ST_BAD;
                    lfbfs_pkg::OP_REMOVE:
                        if (a_bad) rstat_reg <= lfbfs_pkg::ST_BAD;
                        else if (!lbl_has) rstat_reg <= lfbfs_pkg::ST_ABSENT;
                    default:
                        if (a_bad || b_bad) rstat_reg <= lfbfs_pkg::ST_BAD;
                        else if (!lbl_has) rstat_reg <= lfbfs_pkg::ST_EMPTY;
                endcase
            lfbfs_pkg::S_VCLR: clr_reg <= clr_reg + 5'd1;
            lfbfs_pkg::S_CLR:
            begin
                // mark only the start vertex
                vis_reg <= lfbfs_pkg::VERTICES'(1) << a_reg;
                pvalid_reg <= lfbfs_pkg::VERTICES'(1) << a_reg;
                head_reg <= '0;
                tail_reg <= 7'd1;
            end
            lfbfs_pkg::S_POP:
                if (head_reg < tail_reg)
                begin
                    head_reg <= head_reg + 7'd1;
                    e_reg <= '0;
                end
            lfbfs_pkg::S_POP_W: cur_reg <= q_rdata;
            lfbfs_pkg::S_EDGE_RD: e_reg <= e_reg + 5'd1;
            lfbfs_pkg::S_EDGE_W: nx_reg <= edg_rdata;
            lfbfs_pkg::S_NB_CHK:
                if (nb_take)
                begin
                    vis_reg[nx_reg] <= 1'b1;
                    pvalid_reg[nx_reg] <= 1'b1;
                    tail_reg <= tail_reg + 7'd1;
                end
            lfbfs_pkg::S_DONE_CHK:
                if (pvalid_reg[b_reg])
                begin
                    n_reg <= 7'd1;
                    walk_reg <= b_reg;
                end
                else
                    rstat_reg <= lfbfs_pkg::ST_EMPTY;
            lfbfs_pkg::S_WALK_RD:
                if (!walk_more) k_reg <= '0;
            lfbfs_pkg::S_WALK_W:
            begin
                walk_reg <= par_rdata;
                n_reg <= n_reg + 7'd1;
            end
            lfbfs_pkg::S_EMIT: k_reg <= k_reg + 7'd1;
            default: ;
        endcase
    end

    assign busy = (state_reg != lfbfs_pkg::S_IDLE);
endmodule
